>>> hdl/scd_pkg.sv
`timescale 1ns / 1ps

package scd_pkg;

	// Sample and delay line geometry.
	localparam int SAMPLE_W = 24;
	localparam int NUM_CH = 2;
	localparam int DELAY_DEPTH = 2048;
	localparam int ADDR_BITS = $clog2(DELAY_DEPTH);
	localparam int FRAC_BITS = 8;
	localparam int POS_BITS = ADDR_BITS + FRAC_BITS;

	// LFO sine table.
	localparam int PHASE_W = 32;
	localparam int SINE_ENTRIES = 1024;
	localparam int SINE_BITS = $clog2(SINE_ENTRIES);
	localparam int SINE_W = 16;

	// Configuration register widths.
	localparam int STEP_W = 20;
	localparam int AMT_W = 16;
	localparam int DLY_W = 19;
	localparam int CFG_DATA_W = 20;
	localparam int CFG_INDEX_W = 3;

	// Register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DEPTH = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MIX = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SWING = 3'd5;

	// Reset values of the registers.
	localparam logic [STEP_W-1:0] RST_PHASE_STEP = 20'd71583;
	localparam logic [AMT_W-1:0] RST_DEPTH = 16'd36045;
	localparam logic [AMT_W-1:0] RST_MIX = 16'd22938;
	localparam logic [AMT_W-1:0] RST_GAIN = 16'd4096;
	localparam logic [DLY_W-1:0] RST_CENTER = 19'd245760;
	localparam logic [DLY_W-1:0] RST_SWING = 19'd122880;

	// Datapath widths.
	localparam int SD_W = DLY_W + AMT_W;
	localparam int PROD_W = SINE_W + SD_W + 1;
	localparam int OFFS_W = PROD_W - 31;
	localparam int DELAY_W = (POS_BITS + 1 > OFFS_W + 1) ? POS_BITS + 1 : OFFS_W + 1;
	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int WET_W = DIFF_W + FRAC_BITS + 1;
	localparam int MXD_W = WET_W + 1;
	localparam int ACC_W = MXD_W + AMT_W + 1;
	localparam int MIXED_W = ACC_W - 24;
	localparam int GP_W = MIXED_W + AMT_W + 1;
	localparam int RES_W = GP_W - 12;

	// Delay limits: one sample up to two samples short of the line length.
	localparam logic signed [DELAY_W-1:0] DLY_MIN = DELAY_W'(1 << FRAC_BITS);
	localparam logic signed [DELAY_W-1:0] DLY_MAX = DELAY_W'((DELAY_DEPTH - 2) << FRAC_BITS);

	localparam logic signed [RES_W-1:0] SAT_HI = RES_W'((1 << (SAMPLE_W - 1)) - 1);
	localparam logic signed [RES_W-1:0] SAT_LO = -RES_W'(1 << (SAMPLE_W - 1));

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic [STEP_W-1:0] phase_step;
		logic [AMT_W-1:0] depth_amount;
		logic [AMT_W-1:0] mix_amount;
		logic [AMT_W-1:0] output_gain;
		logic [DLY_W-1:0] center_delay;
		logic [DLY_W-1:0] swing_delay;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SCALE,
		ST_OFFSET,
		ST_ADDR,
		ST_READ0,
		ST_READ1,
		ST_INTERP,
		ST_MIX,
		ST_GAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic accept;
		logic lookup;
		logic scale;
		logic offset;
		logic addr;
		logic read0;
		logic read1;
		logic interp;
		logic mix;
		logic gain;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	// Sine entry in Q1.15 from a Q2.30 Taylor series on the folded quadrant.
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	function automatic logic signed [SINE_W-1:0] sine_entry(int k);
		logic [63:0] t;
		logic [63:0] q;
		logic [63:0] u;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t3;
		logic [63:0] t5;
		logic [63:0] t7;
		logic [63:0] t9;
		logic [63:0] t11;
		logic signed [63:0] s;
		logic signed [63:0] r;
		t = (64'(k) << 32) / SINE_ENTRIES;
		q = t >> 30;
		u = t & 64'h3FFF_FFFF;
		if (q[0]) begin
			u = 64'h4000_0000 - u;
		end
		x = (u * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		t3 = ((x * x2) >> 30) / 6;
		t5 = ((t3 * x2) >> 30) / 20;
		t7 = ((t5 * x2) >> 30) / 42;
		t9 = ((t7 * x2) >> 30) / 72;
		t11 = ((t9 * x2) >> 30) / 110;
		s = $signed(x) - $signed(t3) + $signed(t5) - $signed(t7) + $signed(t9) - $signed(t11);
		if (s < 0) begin
			s = 0;
		end
		r = (s + 64'sd16384) >>> 15;
		if (r > 64'sd32767) begin
			r = 64'sd32767;
		end
		if (q >= 2) begin
			r = -r;
		end
		return r[SINE_W-1:0];
	endfunction

	typedef logic signed [SINE_W-1:0] sine_tab_t [SINE_ENTRIES];

	function automatic sine_tab_t build_sine_table();
		sine_tab_t tab;
		for (int k = 0; k < SINE_ENTRIES; k++) begin
			tab[k] = sine_entry(k);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

>>> hdl/scd_cfg_regs.sv
`timescale 1ns / 1ps

// Configuration register file; writes to indexes past the list are dropped.
module scd_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [scd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [scd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output scd_pkg::cfg_t                    cfg
);

	scd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step <= scd_pkg::RST_PHASE_STEP;
			cfg_q.depth_amount <= scd_pkg::RST_DEPTH;
			cfg_q.mix_amount <= scd_pkg::RST_MIX;
			cfg_q.output_gain <= scd_pkg::RST_GAIN;
			cfg_q.center_delay <= scd_pkg::RST_CENTER;
			cfg_q.swing_delay <= scd_pkg::RST_SWING;
		end else if (cfg_write) begin
			unique case (cfg_index)
				scd_pkg::REG_PHASE_STEP: cfg_q.phase_step <= cfg_data[scd_pkg::STEP_W-1:0];
				scd_pkg::REG_DEPTH: cfg_q.depth_amount <= cfg_data[scd_pkg::AMT_W-1:0];
				scd_pkg::REG_MIX: cfg_q.mix_amount <= cfg_data[scd_pkg::AMT_W-1:0];
				scd_pkg::REG_GAIN: cfg_q.output_gain <= cfg_data[scd_pkg::AMT_W-1:0];
				scd_pkg::REG_CENTER: cfg_q.center_delay <= cfg_data[scd_pkg::DLY_W-1:0];
				scd_pkg::REG_SWING: cfg_q.swing_delay <= cfg_data[scd_pkg::DLY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/scd_ctrl.sv
`timescale 1ns / 1ps

// Sequencer: steps a frame through the datapath, one op a cycle but for stalls.
module scd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  scd_pkg::status_t   status,
	output scd_pkg::cmd_t      cmd
);

	scd_pkg::state_t state_q;
	scd_pkg::state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scd_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			scd_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_n = scd_pkg::ST_LOOKUP;
				end
			end
			scd_pkg::ST_LOOKUP: state_n = scd_pkg::ST_SCALE;
			scd_pkg::ST_SCALE: state_n = scd_pkg::ST_OFFSET;
			scd_pkg::ST_OFFSET: state_n = scd_pkg::ST_ADDR;
			scd_pkg::ST_ADDR: state_n = scd_pkg::ST_READ0;
			scd_pkg::ST_READ0: state_n = scd_pkg::ST_READ1;
			scd_pkg::ST_READ1: state_n = scd_pkg::ST_INTERP;
			scd_pkg::ST_INTERP: state_n = scd_pkg::ST_MIX;
			scd_pkg::ST_MIX: state_n = scd_pkg::ST_GAIN;
			scd_pkg::ST_GAIN: state_n = scd_pkg::ST_FINISH;
			scd_pkg::ST_FINISH: begin
				if (status.out_free) begin
					state_n = scd_pkg::ST_IDLE;
				end
			end
			default: state_n = scd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			scd_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.accept = in_valid;
			end
			scd_pkg::ST_LOOKUP: cmd.lookup = 1'b1;
			scd_pkg::ST_SCALE: cmd.scale = 1'b1;
			scd_pkg::ST_OFFSET: cmd.offset = 1'b1;
			scd_pkg::ST_ADDR: cmd.addr = 1'b1;
			scd_pkg::ST_READ0: cmd.read0 = 1'b1;
			scd_pkg::ST_READ1: cmd.read1 = 1'b1;
			scd_pkg::ST_INTERP: cmd.interp = 1'b1;
			scd_pkg::ST_MIX: cmd.mix = 1'b1;
			scd_pkg::ST_GAIN: cmd.gain = 1'b1;
			scd_pkg::ST_FINISH: cmd.finish = status.out_free;
			default: begin
			end
		endcase
	end

endmodule

>>> hdl/scd_datapath.sv
`timescale 1ns / 1ps

// LFO, delay address, delay line memories and mix arithmetic for both channels.
module scd_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  scd_pkg::cmd_t         cmd,
	input  scd_pkg::cfg_t         cfg,
	input  scd_pkg::sample_t      left_in,
	input  scd_pkg::sample_t      right_in,
	output scd_pkg::sample_t      left_out,
	output scd_pkg::sample_t      right_out,
	output logic                  out_valid,
	input  logic                  out_stall,
	output scd_pkg::status_t      status
);

	localparam int NCH = scd_pkg::NUM_CH;
	localparam int AB = scd_pkg::ADDR_BITS;
	localparam int PB = scd_pkg::POS_BITS;
	localparam int FB = scd_pkg::FRAC_BITS;

	// Frame state.
	logic [scd_pkg::PHASE_W-1:0] phase_q;
	logic [AB-1:0] wr_idx_q;
	logic wrapped_q;
	logic out_valid_q;

	// Address path.
	logic signed [scd_pkg::SINE_W-1:0] sine_q;
	logic [scd_pkg::SD_W-1:0] sd_q;
	logic signed [scd_pkg::PROD_W-1:0] prod_q;
	logic signed [scd_pkg::DELAY_W-1:0] delay_q;
	logic [AB-1:0] rd0_addr_q;
	logic [AB-1:0] rd1_addr_q;
	logic [FB-1:0] frac_q;
	logic ok0_q;
	logic ok1_q;

	logic signed [scd_pkg::OFFS_W-1:0] offs_rnd;
	logic [PB-1:0] dly_clamp;
	logic [PB-1:0] rpos;
	logic [AB-1:0] tap0;
	logic [AB-1:0] tap1;

	// Per channel payload.
	scd_pkg::sample_t dry_in [NCH];
	scd_pkg::sample_t dry_q [NCH];
	logic [scd_pkg::SAMPLE_W-1:0] rd_q [NCH];
	scd_pkg::sample_t s0_q [NCH];
	logic signed [scd_pkg::WET_W-1:0] wet_q [NCH];
	logic signed [scd_pkg::ACC_W-1:0] acc_q [NCH];
	logic signed [scd_pkg::GP_W-1:0] gp_q [NCH];
	scd_pkg::sample_t out_q [NCH];

	scd_pkg::sample_t s1 [NCH];
	logic signed [scd_pkg::DIFF_W-1:0] ip_diff [NCH];
	logic signed [scd_pkg::WET_W-1:0] ip_prod [NCH];
	logic signed [scd_pkg::WET_W-1:0] wet_n [NCH];
	logic signed [scd_pkg::MXD_W-1:0] mx_diff [NCH];
	logic signed [scd_pkg::ACC_W-1:0] mx_prod [NCH];
	logic signed [scd_pkg::ACC_W-1:0] acc_n [NCH];
	logic signed [scd_pkg::MIXED_W-1:0] mixed [NCH];
	logic signed [scd_pkg::GP_W-1:0] gp_n [NCH];
	logic signed [scd_pkg::RES_W-1:0] res [NCH];
	scd_pkg::sample_t sat [NCH];

	assign dry_in[0] = left_in;
	assign dry_in[1] = right_in;

	// Delay offset, rounded half up, then clamp and read position.
	always_comb begin
		offs_rnd = $signed(prod_q[scd_pkg::PROD_W-1:31])
			+ $signed({{(scd_pkg::OFFS_W-1){1'b0}}, prod_q[30]});
		if (delay_q < scd_pkg::DLY_MIN) begin
			dly_clamp = scd_pkg::DLY_MIN[PB-1:0];
		end else if (delay_q > scd_pkg::DLY_MAX) begin
			dly_clamp = scd_pkg::DLY_MAX[PB-1:0];
		end else begin
			dly_clamp = delay_q[PB-1:0];
		end
		// The subtraction wraps modulo the line length in fixed point.
		rpos = {wr_idx_q, {FB{1'b0}}} - dly_clamp;
		tap0 = rpos[PB-1:FB];
		tap1 = tap0 + AB'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			sine_q <= scd_pkg::SINE_TABLE[phase_q[scd_pkg::PHASE_W-1 -: scd_pkg::SINE_BITS]];
			sd_q <= cfg.swing_delay * cfg.depth_amount;
		end
		if (cmd.scale) begin
			prod_q <= sine_q * $signed({1'b0, sd_q});
		end
		if (cmd.offset) begin
			delay_q <= $signed({{(scd_pkg::DELAY_W-scd_pkg::DLY_W){1'b0}}, cfg.center_delay})
				+ scd_pkg::DELAY_W'(offs_rnd);
		end
		if (cmd.addr) begin
			rd0_addr_q <= tap0;
			rd1_addr_q <= tap1;
			frac_q <= rpos[FB-1:0];
			// Entries not yet written since reset read as zero.
			ok0_q <= wrapped_q || (tap0 < wr_idx_q);
			ok1_q <= wrapped_q || (tap1 < wr_idx_q);
		end
	end

	// Lane arithmetic.
	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			s1[ch] = ok1_q ? $signed(rd_q[ch]) : '0;
			ip_diff[ch] = scd_pkg::DIFF_W'(s1[ch]) - scd_pkg::DIFF_W'(s0_q[ch]);
			ip_prod[ch] = ip_diff[ch] * $signed({1'b0, frac_q});
			wet_n[ch] = (scd_pkg::WET_W'(s0_q[ch]) <<< FB) + ip_prod[ch];
			// dry*(1-mix) + wet*mix folded into dry + (wet - dry)*mix.
			mx_diff[ch] = scd_pkg::MXD_W'(wet_q[ch]) - (scd_pkg::MXD_W'(dry_q[ch]) <<< FB);
			mx_prod[ch] = mx_diff[ch] * $signed({1'b0, cfg.mix_amount});
			acc_n[ch] = (scd_pkg::ACC_W'(dry_q[ch]) <<< 24) + mx_prod[ch];
			mixed[ch] = $signed(acc_q[ch][scd_pkg::ACC_W-1:24])
				+ $signed({{(scd_pkg::MIXED_W-1){1'b0}}, acc_q[ch][23]});
			gp_n[ch] = mixed[ch] * $signed({1'b0, cfg.output_gain});
			res[ch] = $signed(gp_q[ch][scd_pkg::GP_W-1:12])
				+ $signed({{(scd_pkg::RES_W-1){1'b0}}, gp_q[ch][11]});
			if (res[ch] > scd_pkg::SAT_HI) begin
				sat[ch] = scd_pkg::SAT_HI[scd_pkg::SAMPLE_W-1:0];
			end else if (res[ch] < scd_pkg::SAT_LO) begin
				sat[ch] = scd_pkg::SAT_LO[scd_pkg::SAMPLE_W-1:0];
			end else begin
				sat[ch] = res[ch][scd_pkg::SAMPLE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < NCH; ch++) begin
			if (cmd.accept) begin
				dry_q[ch] <= dry_in[ch];
			end
			if (cmd.read1) begin
				s0_q[ch] <= ok0_q ? $signed(rd_q[ch]) : '0;
			end
			if (cmd.interp) begin
				wet_q[ch] <= wet_n[ch];
			end
			if (cmd.mix) begin
				acc_q[ch] <= acc_n[ch];
			end
			if (cmd.gain) begin
				gp_q[ch] <= gp_n[ch];
			end
			if (cmd.finish) begin
				out_q[ch] <= sat[ch];
			end
		end
	end

	// One single-port delay line per channel: two reads, then the write.
	for (genvar ch = 0; ch < NCH; ch++) begin : g_line
		logic [scd_pkg::SAMPLE_W-1:0] mem [scd_pkg::DELAY_DEPTH];
		logic [AB-1:0] rd_addr;

		assign rd_addr = cmd.read1 ? rd1_addr_q : rd0_addr_q;

		always_ff @(posedge clk) begin
			if (cmd.interp) begin
				mem[wr_idx_q] <= dry_q[ch];
			end
			if (cmd.read0 || cmd.read1) begin
				rd_q[ch] <= mem[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			wr_idx_q <= '0;
			wrapped_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				phase_q <= phase_q + scd_pkg::PHASE_W'(cfg.phase_step);
				wr_idx_q <= wr_idx_q + AB'(1);
				if (wr_idx_q == AB'(scd_pkg::DELAY_DEPTH - 1)) begin
					wrapped_q <= 1'b1;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign left_out = out_q[0];
	assign right_out = out_q[1];

endmodule

>>> hdl/stereo_chorus_delay.sv
// Stereo chorus: LFO-modulated fractional delay with linear interpolation.
// A new frame is taken only once the previous one has finished; each channel's
// delay line is one single-port memory that is read twice and then written for
// every frame.
// Reset clears the sequencer, LFO phase, write pointer, fill flag and the
// registers to their defaults; the delay lines take no clearing pass.
`timescale 1ns / 1ps

module stereo_chorus_delay (
	input  logic                             clk,
	input  logic                             arst_n,
	// Register write port.
	input  logic                             cfg_write,
	input  logic [scd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [scd_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Input frame channel.
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [scd_pkg::SAMPLE_W-1:0] left_in,
	input  logic signed [scd_pkg::SAMPLE_W-1:0] right_in,
	// Result frame channel.
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [scd_pkg::SAMPLE_W-1:0] left_out,
	output logic signed [scd_pkg::SAMPLE_W-1:0] right_out
);

	// The register file holds the LFO rate, depth, mix, gain and the delay
	// centre and swing. Software must write it only while no frame is in flight;
	// the block does not enforce it; the datapath reads it with no shadow copy.
	scd_pkg::cfg_t cfg;

	// The sequencer issues one command per cycle. The datapath reports only
	// whether its output register can take a new result, so the last step of
	// a frame waits there while an earlier result is still held by a stall.
	scd_pkg::cmd_t cmd;
	scd_pkg::status_t status;

	scd_cfg_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	scd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Per frame the datapath looks up the sine, scales it by swing and depth,
	// forms and clamps the fractional delay, reads the two interpolation taps
	// of each line, writes the dry samples, then mixes, applies gain and
	// saturates. A line entry not yet written since reset reads as zero; the
	// write pointer and a wrap flag tell which entries have been filled.
	scd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg),
		.left_in   (left_in),
		.right_in  (right_in),
		.left_out  (left_out),
		.right_out (right_out),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status)
	);

endmodule

>>> dv/chorus_checker.sv
`timescale 1ns / 1ps

module chorus_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [scd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [scd_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic signed [scd_pkg::SAMPLE_W-1:0] left_in,
	input  logic signed [scd_pkg::SAMPLE_W-1:0] right_in,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [scd_pkg::SAMPLE_W-1:0] left_out,
	input  logic signed [scd_pkg::SAMPLE_W-1:0] right_out,
	output int                                  fail_count,
	output int                                  pending
);

	localparam longint DELAY_LO = longint'(1) << scd_pkg::FRAC_BITS;
	localparam longint DELAY_HI = longint'(scd_pkg::DELAY_DEPTH - 2) << scd_pkg::FRAC_BITS;
	localparam longint LINE_SPAN = longint'(scd_pkg::DELAY_DEPTH) << scd_pkg::FRAC_BITS;
	localparam longint OUT_MAX = (longint'(1) << (scd_pkg::SAMPLE_W - 1)) - 1;
	localparam longint OUT_MIN = -(longint'(1) << (scd_pkg::SAMPLE_W - 1));
	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

	typedef struct packed {
		scd_pkg::sample_t left;
		scd_pkg::sample_t right;
	} stereo_t;

	logic signed [scd_pkg::SINE_W-1:0] lfo_sine [scd_pkg::SINE_ENTRIES];

	scd_pkg::sample_t line_mem [scd_pkg::NUM_CH][scd_pkg::DELAY_DEPTH];
	logic [scd_pkg::ADDR_BITS-1:0] wr_ptr;
	logic [scd_pkg::PHASE_W-1:0] lfo_phase;

	logic [scd_pkg::STEP_W-1:0] step;
	logic [scd_pkg::AMT_W-1:0] depth;
	logic [scd_pkg::AMT_W-1:0] mix;
	logic [scd_pkg::AMT_W-1:0] gain;
	logic [scd_pkg::DLY_W-1:0] center;
	logic [scd_pkg::DLY_W-1:0] swing;

	stereo_t processed_q [$];

	// Q1.15 sine from a Q2.30 Taylor series to the eleventh power on the first quadrant.
	function automatic logic signed [scd_pkg::SINE_W-1:0] q15_sine(int k);
		longint unsigned ang;
		longint unsigned quad;
		longint unsigned u;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned p3;
		longint unsigned p5;
		longint unsigned p7;
		longint unsigned p9;
		longint unsigned p11;
		longint s;
		longint r;
		ang = (longint'(k) << 32) / scd_pkg::SINE_ENTRIES;
		quad = ang >> 30;
		u = ang & 64'h3FFF_FFFF;
		if (quad[0]) begin
			u = 64'h4000_0000 - u;
		end
		x = (u * QUARTER_TURN_Q30) >> 30;
		x2 = (x * x) >> 30;
		p3 = ((x * x2) >> 30) / 6;
		p5 = ((p3 * x2) >> 30) / 20;
		p7 = ((p5 * x2) >> 30) / 42;
		p9 = ((p7 * x2) >> 30) / 72;
		p11 = ((p9 * x2) >> 30) / 110;
		s = longint'(x) - longint'(p3) + longint'(p5) - longint'(p7) + longint'(p9)
			- longint'(p11);
		if (s < 0) begin
			s = 0;
		end
		r = (s + 16384) >>> 15;
		if (r > 32767) begin
			r = 32767;
		end
		if (quad >= 2) begin
			r = -r;
		end
		return r[scd_pkg::SINE_W-1:0];
	endfunction

	function automatic longint round_half_up(longint v, int sh);
		return (v + (longint'(1) << (sh - 1))) >>> sh;
	endfunction

	initial begin
		for (int k = 0; k < scd_pkg::SINE_ENTRIES; k++) begin
			lfo_sine[k] = q15_sine(k);
		end
	end

	task automatic process_frame(input scd_pkg::sample_t dry_l, input scd_pkg::sample_t dry_r);
		scd_pkg::sample_t dry [scd_pkg::NUM_CH];
		scd_pkg::sample_t wet_out [scd_pkg::NUM_CH];
		stereo_t frame;
		longint sn;
		longint dly;
		longint rpos;
		longint frac;
		longint wet;
		longint acc;
		longint mixed;
		longint res;
		int unsigned tap0;
		int unsigned tap1;
		dry[0] = dry_l;
		dry[1] = dry_r;
		sn = lfo_sine[lfo_phase[scd_pkg::PHASE_W-1 -: scd_pkg::SINE_BITS]];
		dly = longint'(center) + round_half_up(sn * longint'(swing) * longint'(depth), 31);
		if (dly < DELAY_LO) begin
			dly = DELAY_LO;
		end
		if (dly > DELAY_HI) begin
			dly = DELAY_HI;
		end
		rpos = (longint'(wr_ptr) << scd_pkg::FRAC_BITS) - dly;
		if (rpos < 0) begin
			rpos += LINE_SPAN;
		end
		tap0 = 32'(rpos >>> scd_pkg::FRAC_BITS) % scd_pkg::DELAY_DEPTH;
		frac = rpos & 255;
		tap1 = (tap0 + 1) % scd_pkg::DELAY_DEPTH;
		for (int c = 0; c < scd_pkg::NUM_CH; c++) begin
			wet = longint'(line_mem[c][tap0]) * (256 - frac)
				+ longint'(line_mem[c][tap1]) * frac;
			acc = longint'(dry[c]) * 256 * (65536 - longint'(mix)) + wet * longint'(mix);
			mixed = round_half_up(acc, 24);
			line_mem[c][wr_ptr] = dry[c];
			res = round_half_up(mixed * longint'(gain), 12);
			if (res > OUT_MAX) begin
				res = OUT_MAX;
			end
			if (res < OUT_MIN) begin
				res = OUT_MIN;
			end
			wet_out[c] = res[scd_pkg::SAMPLE_W-1:0];
		end
		frame.left = wet_out[0];
		frame.right = wet_out[1];
		processed_q.push_back(frame);
		wr_ptr = wr_ptr + 1'b1;
		lfo_phase = lfo_phase + scd_pkg::PHASE_W'(step);
	endtask

	always @(posedge clk or negedge arst_n) begin
		stereo_t want;
		if (!arst_n) begin
			for (int c = 0; c < scd_pkg::NUM_CH; c++) begin
				for (int i = 0; i < scd_pkg::DELAY_DEPTH; i++) begin
					line_mem[c][i] = '0;
				end
			end
			wr_ptr = '0;
			lfo_phase = '0;
			step = scd_pkg::RST_PHASE_STEP;
			depth = scd_pkg::RST_DEPTH;
			mix = scd_pkg::RST_MIX;
			gain = scd_pkg::RST_GAIN;
			center = scd_pkg::RST_CENTER;
			swing = scd_pkg::RST_SWING;
			processed_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
				scd_pkg::REG_PHASE_STEP: step = cfg_data[scd_pkg::STEP_W-1:0];
				scd_pkg::REG_DEPTH: depth = cfg_data[scd_pkg::AMT_W-1:0];
				scd_pkg::REG_MIX: mix = cfg_data[scd_pkg::AMT_W-1:0];
				scd_pkg::REG_GAIN: gain = cfg_data[scd_pkg::AMT_W-1:0];
				scd_pkg::REG_CENTER: center = cfg_data[scd_pkg::DLY_W-1:0];
				scd_pkg::REG_SWING: swing = cfg_data[scd_pkg::DLY_W-1:0];
				default: ;
				endcase
			end
			// Results are checked before this edge's input is predicted so that an
			// unexpected result never pairs with a frame accepted on the same edge.
			if (out_valid && !out_stall) begin
				if (processed_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: unexpected result left %0d right %0d", $realtime,
							left_out, right_out);
					end
				end else begin
					want = processed_q.pop_front();
					if (left_out !== want.left || right_out !== want.right) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: mismatch left exp %0d got %0d, right exp %0d got %0d",
								$realtime, want.left, left_out, want.right, right_out);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				process_frame(left_in, right_in);
			end
		end
		pending = processed_q.size();
	end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam scd_pkg::sample_t PEAK_POS =
		scd_pkg::sample_t'((1 << (scd_pkg::SAMPLE_W - 1)) - 1);
	localparam scd_pkg::sample_t PEAK_NEG = scd_pkg::sample_t'(1 << (scd_pkg::SAMPLE_W - 1));
	localparam int RANDOM_PHASES = 16;
	localparam int FRAMES_PER_PHASE = 106;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [scd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [scd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	scd_pkg::sample_t left_in = '0;
	scd_pkg::sample_t right_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	scd_pkg::sample_t left_out;
	scd_pkg::sample_t right_out;

	int fail_count;
	int pending;

	// Percent of cycles in which the source holds back a frame and the sink stalls.
	int idle_pct = 0;
	int stall_pct = 0;

	stereo_chorus_delay uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.left_in(left_in),
		.right_in(right_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.left_out(left_out),
		.right_out(right_out)
	);

	chorus_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.left_in(left_in),
		.right_in(right_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.left_out(left_out),
		.right_out(right_out),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// The sink stalls on a fresh coin toss every cycle, so stalls land on every
	// stage of the block's sequencer, including while a result is waiting.
	always @(posedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	// Offers one frame and returns at the edge that completes its transfer.
	// The caller is always sitting at a rising edge, and in_valid is only
	// assigned once per edge: it stays high when frames follow back to back.
	task automatic offer_frame(input scd_pkg::sample_t l, input scd_pkg::sample_t r);
		bit taken;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		left_in <= l;
		right_in <= r;
		// in_stall is settled by the falling edge, so sampling it there tells
		// whether the next rising edge completes the transfer.
		forever begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
			if (taken) begin
				break;
			end
		end
	endtask

	// Stops the source and waits until every predicted result has come back,
	// so that the registers may be rewritten while the block is idle.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) begin
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	// Writes all six registers back to back, then the two unused indexes with
	// random data, which the block must ignore.
	task automatic program_chorus(input int unsigned step, input int unsigned depth,
			input int unsigned mix, input int unsigned gain, input int unsigned center,
			input int unsigned swing);
		logic [scd_pkg::CFG_DATA_W-1:0] vals [6];
		logic [scd_pkg::CFG_INDEX_W-1:0] idx [6];
		vals[0] = scd_pkg::CFG_DATA_W'(step);
		vals[1] = scd_pkg::CFG_DATA_W'(depth);
		vals[2] = scd_pkg::CFG_DATA_W'(mix);
		vals[3] = scd_pkg::CFG_DATA_W'(gain);
		vals[4] = scd_pkg::CFG_DATA_W'(center);
		vals[5] = scd_pkg::CFG_DATA_W'(swing);
		idx[0] = scd_pkg::REG_PHASE_STEP;
		idx[1] = scd_pkg::REG_DEPTH;
		idx[2] = scd_pkg::REG_MIX;
		idx[3] = scd_pkg::REG_GAIN;
		idx[4] = scd_pkg::REG_CENTER;
		idx[5] = scd_pkg::REG_SWING;
		for (int i = 0; i < 6; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		for (int i = 6; i < (1 << scd_pkg::CFG_INDEX_W); i++) begin
			cfg_write <= 1'b1;
			cfg_index <= scd_pkg::CFG_INDEX_W'(i);
			cfg_data <= scd_pkg::CFG_DATA_W'($urandom);
			@(posedge clk);
		end
		cfg_write <= 1'b0;
	endtask

	// Picks either end of a range now and then, otherwise anything in between.
	function automatic int unsigned span_pick(input int unsigned lo, input int unsigned hi);
		case ($urandom_range(7))
		0: return lo;
		1: return hi;
		default: return $urandom_range(hi, lo);
		endcase
	endfunction

	// Mostly full-scale random audio, with the rails and near-silence mixed in.
	function automatic scd_pkg::sample_t draw_sample();
		case ($urandom_range(9))
		0: return PEAK_POS;
		1: return PEAK_NEG;
		2: return scd_pkg::sample_t'($signed($urandom_range(512)) - 256);
		default: return scd_pkg::sample_t'($urandom);
		endcase
	endfunction

	initial begin
		int unsigned center;
		int unsigned gain;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames on the reset settings: silence, both rails, mixed
		// polarity and alternating bit patterns so every sample bit toggles.
		offer_frame('0, '0);
		offer_frame(PEAK_POS, PEAK_POS);
		offer_frame(PEAK_NEG, PEAK_NEG);
		offer_frame(PEAK_POS, PEAK_NEG);
		offer_frame(scd_pkg::sample_t'(24'h555555), scd_pkg::sample_t'(24'hAAAAAA));
		offer_frame(scd_pkg::sample_t'(-1), scd_pkg::sample_t'(1));
		drain();

		// Centre and swing at zero push the delay below one sample, so it is
		// clamped up; mix at zero passes the dry signal and full gain saturates.
		program_chorus(0, 0, 0, 65535, 0, 0);
		offer_frame(PEAK_POS, PEAK_NEG);
		offer_frame(scd_pkg::sample_t'(1), scd_pkg::sample_t'(-1));
		offer_frame(scd_pkg::sample_t'(300), scd_pkg::sample_t'(-300));
		offer_frame(scd_pkg::sample_t'(24'hAAAAAA), scd_pkg::sample_t'(24'h555555));
		offer_frame(PEAK_NEG, PEAK_POS);
		drain();

		// All but the gain at maximum, gain at unity: the delay is clamped down to
		// two samples short of the line length; output all wet, LFO at full speed.
		program_chorus((1 << scd_pkg::STEP_W) - 1, 65535, 65535, 4096,
			(1 << scd_pkg::DLY_W) - 1, (1 << scd_pkg::DLY_W) - 1);
		for (int i = 0; i < 6; i++) begin
			offer_frame(draw_sample(), draw_sample());
		end
		drain();

		// Shortest centre with a huge swing: on the negative half of the sine
		// the delay goes below range, and long delays make the read position
		// wrap behind the write pointer.
		program_chorus(12345, 65535, 32768, 8192, 256, (1 << scd_pkg::DLY_W) - 1);
		for (int i = 0; i < 6; i++) begin
			offer_frame(draw_sample(), draw_sample());
		end
		drain();

		// Random phases, each with new settings and one of four traffic
		// patterns: free flowing, a slow source, a slow sink, and both.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph % 4)
			0: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct = 55;
				stall_pct = 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct = 55;
			end
			default: begin
				idle_pct = 24;
				stall_pct = 24;
			end
			endcase
			// Half the phases get a short centre delay, the rest any centre in range.
			if ($urandom_range(1) == 0) begin
				center = $urandom_range(64 << scd_pkg::FRAC_BITS, 1 << scd_pkg::FRAC_BITS);
			end else begin
				center = span_pick(0, (1 << scd_pkg::DLY_W) - 1);
			end
			if ($urandom_range(1) == 0) begin
				gain = $urandom_range(8192, 2048);
			end else begin
				gain = span_pick(0, 65535);
			end
			program_chorus(span_pick(0, (1 << scd_pkg::STEP_W) - 1), span_pick(0, 65535),
				span_pick(0, 65535), gain, center, span_pick(0, (1 << scd_pkg::DLY_W) - 1));
			for (int i = 0; i < FRAMES_PER_PHASE; i++) begin
				offer_frame(draw_sample(), draw_sample());
			end
			drain();
		end

		// Let the sink run free and give the block time to show any stray
		// transfer after the last expected one.
		stall_pct = 0;
		repeat (30) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> files.f
hdl/scd_pkg.sv
hdl/scd_cfg_regs.sv
hdl/scd_ctrl.sv
hdl/scd_datapath.sv
hdl/stereo_chorus_delay.sv
dv/chorus_checker.sv
dv/testbench.sv
